FILE: design/tle_pkg.sv
// Shared constants, types, weight table and microcode store of the loss interval estimator.
package tle_pkg;

  localparam int unsigned MaxIntervalsDef = 9;
  localparam int unsigned WeightCount     = 8;

  localparam int unsigned SeqW    = 16;
  localparam int unsigned IntW    = 16;
  localparam int unsigned WeightW = 4;
  localparam int unsigned WsumW   = 6;
  localparam int unsigned SumW    = 22;
  localparam int unsigned FracW   = 8;
  localparam int unsigned DivW    = SumW + FracW;
  localparam int unsigned AvgW    = 24;
  localparam int unsigned WidxW   = 3;
  localparam int unsigned PcW     = 3;
  localparam int unsigned LoopW   = 4;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_MAC,
    OP_MAX,
    OP_DIV,
    OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_LOOP,
    COND_OUT_BUSY
  } cond_e;

  typedef logic [PcW-1:0]   pc_t;
  typedef logic [LoopW-1:0] loop_t;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   jmp;
    pc_t   nxt;
    loop_t last;
  } ucode_t;

  localparam pc_t StepWait = 3'd0;
  localparam pc_t StepMac  = 3'd1;
  localparam pc_t StepMax  = 3'd2;
  localparam pc_t StepDiv  = 3'd3;
  localparam pc_t StepOut  = 3'd4;

  localparam loop_t MacLast = LoopW'(WeightCount - 1);
  localparam loop_t DivLast = LoopW'(DivW / 2 - 1);

  // The program: the jump target is taken when the condition holds, else the next step.
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      StepWait: w = '{op: OP_WAIT, cond: COND_NO_INPUT, jmp: StepWait, nxt: StepMac,
                      last: '0};
      StepMac:  w = '{op: OP_MAC, cond: COND_LOOP, jmp: StepMac, nxt: StepMax,
                      last: MacLast};
      StepMax:  w = '{op: OP_MAX, cond: COND_NEVER, jmp: StepDiv, nxt: StepDiv,
                      last: '0};
      StepDiv:  w = '{op: OP_DIV, cond: COND_LOOP, jmp: StepDiv, nxt: StepOut,
                      last: DivLast};
      StepOut:  w = '{op: OP_OUT, cond: COND_OUT_BUSY, jmp: StepOut, nxt: StepWait,
                      last: '0};
      default:  w = '{op: OP_WAIT, cond: COND_NEVER, jmp: StepWait, nxt: StepWait,
                      last: '0};
    endcase
    return w;
  endfunction

  // Interval weights in tenths, newest interval first.
  function automatic logic [WeightW-1:0] weight_tenths(input logic [WidxW-1:0] k);
    logic [WeightW-1:0] w;
    case (k)
      3'd0, 3'd1, 3'd2, 3'd3: w = 4'd10;
      3'd4:                   w = 4'd8;
      3'd5:                   w = 4'd6;
      3'd6:                   w = 4'd4;
      3'd7:                   w = 4'd2;
      default:                w = '0;
    endcase
    return w;
  endfunction

endpackage

FILE: design/tle_if.sv
// Valid/ready channel interfaces for packet items and estimate results.
interface tle_in_if;
  import tle_pkg::*;

  logic            valid;
  logic            ready;
  logic [SeqW-1:0] seq_num;
  logic            restart;

  modport source (output valid, output seq_num, output restart, input ready);
  modport sink   (input valid, input seq_num, input restart, output ready);
endinterface

interface tle_out_if;
  import tle_pkg::*;

  logic            valid;
  logic            ready;
  logic            valid_res;
  logic [AvgW-1:0] avg_interval_q8;
  logic [IntW-1:0] current_interval;

  modport source (output valid, output valid_res, output avg_interval_q8,
                  output current_interval, input ready);
  modport sink   (input valid, input valid_res, input avg_interval_q8,
                  input current_interval, output ready);
endinterface

FILE: design/tfrc_loss_interval_estimator.sv
// Loss interval estimator: interval history, weighted sums and Q8 average, run by microcode.
// From the transfer of an item to its result in the output register the sequencer runs the
// multiply-accumulate steps, a compare, the divider steps and a load; the history is updated
// at the transfer. An item is finished before the next is taken: the load step waits while
// an unread result is held, and a new item is taken only in the wait step.
// Reset (rst_ni low, asynchronous) empties the history: newest interval 0, one interval
// in use, expected sequence 0, no loss seen, sequencer in the wait step, output empty.
module tfrc_loss_interval_estimator #(
  parameter int unsigned MAX_INTERVALS = tle_pkg::MaxIntervalsDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  tle_in_if.sink    in_i,
  tle_out_if.source out_o
);
  import tle_pkg::*;

  // The count must be able to hold MAX_INTERVALS itself.
  localparam int unsigned CntW      = $clog2(MAX_INTERVALS + 1);
  // The working copy holds one entry beyond the eight weights for the older sum.
  localparam int unsigned WorkDepth = WeightCount + 1;
  localparam int unsigned LoadN     = (MAX_INTERVALS < WorkDepth) ? MAX_INTERVALS : WorkDepth;
  localparam int unsigned CmpW      = CntW + WidxW;

  // Sequencer.
  pc_t    pc_q, pc_d;
  loop_t  loop_q, loop_d;
  ucode_t uc;
  logic   cond_true;

  // Architectural state of the estimator.
  logic [IntW-1:0] store_q [MAX_INTERVALS];
  logic [IntW-1:0] store_d [MAX_INTERVALS];
  logic [CntW-1:0] count_q, count_d;
  logic [SeqW-1:0] exp_q, exp_d;
  logic            seen_q, seen_d;

  // Datapath registers.
  logic [IntW-1:0]  work_q [WorkDepth];
  logic [IntW-1:0]  work_d [WorkDepth];
  logic [SumW-1:0]  sum_new_q, sum_new_d;
  logic [SumW-1:0]  sum_old_q, sum_old_d;
  logic [WsumW-1:0] wsum_q, wsum_d;
  logic [DivW-1:0]  quo_q, quo_d;
  logic [WsumW-1:0] rem_q, rem_d;

  // Output register.
  logic            out_valid_q, out_valid_d;
  logic            res_valid_q;
  logic [AvgW-1:0] res_avg_q;
  logic [IntW-1:0] res_cur_q;
  logic            out_load;
  logic            res_valid;

  logic                    in_fire;
  logic [WidxW-1:0]        widx;
  logic [CmpW-1:0]         term_pos;
  logic                    term_used;
  logic [WeightW-1:0]      w_eff;
  logic [IntW+WeightW-1:0] prod_new;
  logic [IntW+WeightW-1:0] prod_old;
  logic [SumW-1:0]         best;
  logic [WsumW:0]          div_r1, div_r2;
  logic [WsumW-1:0]        div_m1;
  logic                    div_b1, div_b2;

  // ---------------------------------------------------------------------------------------
  // Microcode fetch and branch. Each control word names the datapath operation, a branch
  // condition, a taken target and a fall-through target. Loop steps repeat until the loop
  // counter reaches the limit carried in the control word.
  // ---------------------------------------------------------------------------------------
  assign uc = ucode_rom(pc_q);

  always_comb begin
    case (uc.cond)
      COND_NEVER:    cond_true = 1'b0;
      COND_NO_INPUT: cond_true = !in_i.valid;
      COND_LOOP:     cond_true = (loop_q != uc.last);
      COND_OUT_BUSY: cond_true = out_valid_q && !out_o.ready;
      default:       cond_true = 1'b0;
    endcase
  end

  assign pc_d   = cond_true ? uc.jmp : uc.nxt;
  assign loop_d = (cond_true && (uc.cond == COND_LOOP)) ? loop_q + 1'b1 : '0;

  // Items are taken only in the wait step.
  assign in_i.ready = (uc.op == OP_WAIT);
  assign in_fire    = in_i.valid && (uc.op == OP_WAIT);

  // ---------------------------------------------------------------------------------------
  // Multiply-accumulate step. The working copy shifts one place per step, so the newest
  // unsummed interval is always at entry zero and its older neighbor at entry one. A term
  // counts only while its older neighbor is among the intervals in use.
  // ---------------------------------------------------------------------------------------
  assign widx      = loop_q[WidxW-1:0];
  assign term_pos  = CmpW'(widx) + CmpW'(1);
  assign term_used = (term_pos < CmpW'(count_q));
  assign w_eff     = term_used ? weight_tenths(widx) : '0;
  assign prod_new  = work_q[0] * w_eff;
  assign prod_old  = work_q[1] * w_eff;
  assign best      = (sum_new_q > sum_old_q) ? sum_new_q : sum_old_q;

  // ---------------------------------------------------------------------------------------
  // Divider step: two restoring quotient bits per cycle. The remainder stays below the
  // weight sum, so it fits the weight sum's width.
  // ---------------------------------------------------------------------------------------
  assign div_r1 = {rem_q, quo_q[DivW-1]};
  assign div_b1 = (div_r1 >= {1'b0, wsum_q});
  assign div_m1 = div_b1 ? WsumW'(div_r1 - {1'b0, wsum_q}) : div_r1[WsumW-1:0];
  assign div_r2 = {div_m1, quo_q[DivW-2]};
  assign div_b2 = (div_r2 >= {1'b0, wsum_q});

  // The estimate is meaningful once a gap has been seen and two intervals are in use.
  assign res_valid = seen_q && (count_q >= CntW'(2));
  assign out_load  = (uc.op == OP_OUT) && !cond_true;

  always_comb begin
    store_d     = store_q;
    count_d     = count_q;
    exp_d       = exp_q;
    seen_d      = seen_q;
    work_d      = work_q;
    sum_new_d   = sum_new_q;
    sum_old_d   = sum_old_q;
    wsum_d      = wsum_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !out_o.ready;

    case (uc.op)
      OP_WAIT: begin
        sum_new_d = '0;
        sum_old_d = '0;
        wsum_d    = '0;
        if (in_fire) begin
          if (in_i.restart) begin
            // History is emptied and this packet opens the first interval.
            for (int j = 0; j < MAX_INTERVALS; j++) begin
              store_d[j] = '0;
            end
            store_d[0] = IntW'(1);
            count_d    = CntW'(1);
            seen_d     = 1'b0;
            exp_d      = in_i.seq_num + 1'b1;
          end else if (in_i.seq_num == exp_q) begin
            // In order: lengthen the open interval, saturating.
            if (store_q[0] != '1) begin
              store_d[0] = store_q[0] + 1'b1;
            end
            exp_d = exp_q + 1'b1;
          end else begin
            // Any other sequence number is a gap, also one behind the expected number.
            for (int j = 1; j < MAX_INTERVALS; j++) begin
              store_d[j] = store_q[j-1];
            end
            store_d[0] = IntW'(1);
            if (count_q < CntW'(MAX_INTERVALS)) begin
              count_d = count_q + 1'b1;
            end
            exp_d  = in_i.seq_num + 1'b1;
            seen_d = 1'b1;
          end
          for (int j = 0; j < WorkDepth; j++) begin
            work_d[j] = '0;
          end
          for (int j = 0; j < LoadN; j++) begin
            work_d[j] = store_d[j];
          end
        end
      end

      OP_MAC: begin
        sum_new_d = sum_new_q + SumW'(prod_new);
        sum_old_d = sum_old_q + SumW'(prod_old);
        wsum_d    = wsum_q + WsumW'(w_eff);
        for (int j = 0; j < WorkDepth - 1; j++) begin
          work_d[j] = work_q[j+1];
        end
        work_d[WorkDepth-1] = '0;
      end

      OP_MAX: begin
        quo_d = {best, {FracW{1'b0}}};
        rem_d = '0;
      end

      OP_DIV: begin
        rem_d = div_b2 ? WsumW'(div_r2 - {1'b0, wsum_q}) : div_r2[WsumW-1:0];
        quo_d = {quo_q[DivW-3:0], div_b1, div_b2};
      end

      OP_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= StepWait;
      loop_q      <= '0;
      count_q     <= CntW'(1);
      exp_q       <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < MAX_INTERVALS; j++) begin
        store_q[j] <= '0;
      end
    end else begin
      pc_q        <= pc_d;
      loop_q      <= loop_d;
      count_q     <= count_d;
      exp_q       <= exp_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
      store_q     <= store_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q    <= work_d;
    sum_new_q <= sum_new_d;
    sum_old_q <= sum_old_d;
    wsum_q    <= wsum_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    if (out_load) begin
      res_valid_q <= res_valid;
      res_avg_q   <= res_valid ? quo_q[AvgW-1:0] : '0;
      res_cur_q   <= res_valid ? store_q[0] : '0;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.valid_res        = res_valid_q;
  assign out_o.avg_interval_q8  = res_avg_q;
  assign out_o.current_interval = res_cur_q;

endmodule

FILE: design/tle_checker.sv
// Port-level assertions for the loss interval estimator and their bind to the top level.
module tle_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      valid_res_i,
  input logic [tle_pkg::AvgW-1:0]  avg_i,
  input logic [tle_pkg::IntW-1:0]  cur_i
);
  import tle_pkg::*;

  // One item at a time: after a transfer in, the input side closes.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken again right after a transfer");

  // Before the first loss both estimates read zero.
  a_zero_before_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !valid_res_i) |-> (avg_i == '0) && (cur_i == '0))
    else $error("nonzero estimate without a loss");

  // After a loss the open interval holds at least the packet that opened it.
  a_open_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && valid_res_i) |-> (cur_i != '0))
    else $error("open interval empty after a loss");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      out_valid_i && $stable(valid_res_i) && $stable(avg_i) && $stable(cur_i))
    else $error("stalled result changed");

endmodule

bind tfrc_loss_interval_estimator tle_checker u_tle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .valid_res_i (out_o.valid_res),
  .avg_i       (out_o.avg_interval_q8),
  .cur_i       (out_o.current_interval)
);

FILE: tb/tle_estimate_checker.sv
// Checker that predicts every loss estimate from the accepted packet transfers and compares.
`timescale 1ns / 1ps

module tle_estimate_checker #(
  parameter int unsigned MAX_INTERVALS = tle_pkg::MaxIntervalsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [tle_pkg::SeqW-1:0] seq_num_i,
  input  logic                     restart_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic                     valid_res_i,
  input  logic [tle_pkg::AvgW-1:0] avg_interval_q8_i,
  input  logic [tle_pkg::IntW-1:0] current_interval_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o,
  output int unsigned              checked_o
);
  import tle_pkg::*;

  typedef struct packed {
    logic            valid_res;
    logic [AvgW-1:0] avg_q8;
    logic [IntW-1:0] current;
  } loss_estimate_t;

  loss_estimate_t  estimate_q[$];
  logic [IntW-1:0] interval_hist[MAX_INTERVALS];
  int unsigned     intervals_used;
  logic [SeqW-1:0] next_seq;
  logic            loss_seen;
  int unsigned     mismatches = 0;
  int unsigned     estimates_checked = 0;
  int unsigned     waiting = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;
  assign checked_o    = estimates_checked;

  // Interval weights in tenths, newest first; positions past eight carry no weight.
  function automatic int unsigned tenths_weight(input int unsigned k);
    case (k)
      0, 1, 2, 3: return 10;
      4:          return 8;
      5:          return 6;
      6:          return 4;
      7:          return 2;
      default:    return 0;
    endcase
  endfunction

  task automatic clear_history();
    foreach (interval_hist[i]) interval_hist[i] = '0;
    intervals_used = 1;
    loss_seen      = 1'b0;
  endtask

  // Advances the interval history by one packet and forms the estimate it yields.
  task automatic predict_estimate(input logic [SeqW-1:0] seq, input logic restart,
                                  output loss_estimate_t est);
    longint unsigned sum_newer;
    longint unsigned sum_older;
    longint unsigned wsum;
    longint unsigned best;
    int unsigned     w;
    int              i;
    sum_newer = 0;
    sum_older = 0;
    wsum      = 0;
    if (restart) begin
      clear_history();
      next_seq = seq;
    end
    if (seq == next_seq) begin
      if (interval_hist[0] != '1) interval_hist[0] = interval_hist[0] + 1'b1;
      next_seq = next_seq + 1'b1;
    end else begin
      for (i = MAX_INTERVALS - 1; i > 0; i--) interval_hist[i] = interval_hist[i-1];
      interval_hist[0] = IntW'(1);
      if (intervals_used < MAX_INTERVALS) intervals_used++;
      next_seq  = seq + 1'b1;
      loss_seen = 1'b1;
    end
    est = '0;
    if (loss_seen && intervals_used >= 2) begin
      for (i = 0; i + 1 < intervals_used; i++) begin
        w = tenths_weight(i);
        sum_newer += longint'(interval_hist[i]) * w;
        sum_older += longint'(interval_hist[i+1]) * w;
        wsum      += w;
      end
      best          = (sum_newer > sum_older) ? sum_newer : sum_older;
      est.valid_res = 1'b1;
      est.avg_q8    = AvgW'((best << FracW) / wsum);
      est.current   = interval_hist[0];
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    loss_estimate_t want;
    loss_estimate_t fresh;
    if (!rst_ni) begin
      clear_history();
      next_seq = '0;
      estimate_q.delete();
    end else begin
      // A result always belongs to an earlier packet, so it is checked first.
      if (out_valid_i && out_ready_i) begin
        if (estimate_q.size() == 0) begin
          $display("%0t: estimate with none expected, expected nothing, got %0d/%0d/%0d",
                   $time, valid_res_i, avg_interval_q8_i, current_interval_i);
          mismatches++;
        end else begin
          want = estimate_q[0];
          estimate_q.delete(0);
          check_field("valid_res", want.valid_res, valid_res_i);
          check_field("avg_interval_q8", want.avg_q8, avg_interval_q8_i);
          check_field("current_interval", want.current, current_interval_i);
          estimates_checked++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_estimate(seq_num_i, restart_i, fresh);
        estimate_q = {estimate_q, fresh};
      end
    end
    waiting = estimate_q.size();
  end

endmodule

FILE: tb/tfrc_loss_interval_estimator_tb.sv
// Top of the loss interval estimator testbench: clock, reset, packet stimulus and verdict.
`timescale 1ns / 1ps

module tfrc_loss_interval_estimator_tb;
  import tle_pkg::*;

  logic clk;
  logic rst_n = 1'b0;

  tle_in_if  in_ch();
  tle_out_if out_ch();

  // The checker sits beside the block and only watches both channels.
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  // Idle shares in percent; the stimulus process moves them from phase to phase.
  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 75;

  // Stimulus statistics for the closing summary.
  int unsigned items_sent    = 0;
  int unsigned restarts_sent = 0;
  int unsigned gaps_sent     = 0;
  logic [SeqW-1:0] next_seq  = '0;

  // Directed packets: bit 16 is the restart flag, the low bits the sequence number.
  localparam logic [16:0] Directed[25] = '{
    {1'b0, 16'h0000}, {1'b0, 16'h0001}, {1'b0, 16'h0002}, {1'b0, 16'h000A},
    {1'b0, 16'h000B}, {1'b0, 16'h000B}, {1'b0, 16'h0005}, {1'b0, 16'h0006},
    {1'b0, 16'hFFFF}, {1'b0, 16'h0000}, {1'b0, 16'h0001}, {1'b0, 16'h0003},
    {1'b0, 16'h0005}, {1'b0, 16'h0007}, {1'b0, 16'h0009}, {1'b0, 16'h000B},
    {1'b0, 16'h000D}, {1'b0, 16'h000F}, {1'b0, 16'h0011}, {1'b1, 16'h8000},
    {1'b0, 16'h8001}, {1'b1, 16'h7FFF}, {1'b1, 16'hFFFF}, {1'b0, 16'h0000},
    {1'b0, 16'h1234}
  };

  tfrc_loss_interval_estimator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  tle_estimate_checker checker_i (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_ch.valid),
    .in_ready_i         (in_ch.ready),
    .seq_num_i          (in_ch.seq_num),
    .restart_i          (in_ch.restart),
    .out_valid_i        (out_ch.valid),
    .out_ready_i        (out_ch.ready),
    .valid_res_i        (out_ch.valid_res),
    .avg_interval_q8_i  (out_ch.avg_interval_q8),
    .current_interval_i (out_ch.current_interval),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .checked_o          (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver decides afresh each cycle whether it can take a result.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one packet and returns once the block has taken it. Idle cycles are
  // inserted before the offer; valid is written exactly once per falling edge,
  // so back-to-back transfers keep it high without a glitch.
  task automatic send_packet(input logic [SeqW-1:0] seq, input logic restart);
    bit offered;
    offered = 1'b0;
    while (!offered) begin
      @(negedge clk);
      if ($urandom_range(99) < send_idle_pct) begin
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid   <= 1'b1;
        in_ch.seq_num <= seq;
        in_ch.restart <= restart;
        offered = 1'b1;
      end
    end
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (restart) restarts_sent++;
    else if (seq != next_seq) gaps_sent++;
    next_seq = seq + 1'b1;
  endtask

  initial begin : stimulus
    int unsigned     in_order_pct;
    int unsigned     pick;
    logic [SeqW-1:0] seq;
    logic            restart;
    // Every block input is known from time zero; the sender changes them only at
    // falling edges, so a rising edge always sees settled values.
    in_ch.valid   = 1'b0;
    in_ch.seq_num = '0;
    in_ch.restart = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: first packets before any loss, a forward gap, a repeat and an
    // old number, a wrap through zero, enough gaps to fill the history and push out
    // the oldest interval, and restarts at the middle and the top of the number range.
    foreach (Directed[k]) send_packet(Directed[k][SeqW-1:0], Directed[k][16]);

    // Random part: mostly in-order runs broken by gaps, so intervals of many lengths
    // pass through a full history. The share of in-order packets is redrawn now and
    // then to mix short and long intervals. Restarts are rare so the history fills.
    in_order_pct = 80;
    for (int n = 0; n < 1225; n++) begin
      if (n == 392) begin
        send_idle_pct = 75;
        recv_idle_pct = 33;
      end else if (n == 809) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n % 64 == 0) in_order_pct = $urandom_range(97, 55);
      pick    = $urandom_range(99);
      restart = 1'b0;
      if (pick < in_order_pct) begin
        seq = next_seq;
      end else if (pick < 98) begin
        case ($urandom_range(3))
          0, 1:    seq = next_seq + SeqW'($urandom_range(40, 1));
          2:       seq = next_seq - SeqW'($urandom_range(4, 1));
          default: seq = SeqW'($urandom);
        endcase
      end else begin
        restart = 1'b1;
        seq     = $urandom_range(1) ? next_seq : SeqW'($urandom);
      end
      send_packet(seq, restart);
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Drain: every expected estimate must arrive; the watchdog catches a hang.
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d packets (%0d restarts, %0d loss gaps), checked %0d estimates.",
             items_sent, restarts_sent, gaps_sent, checked);
    $display("Covered wrap, repeats, old numbers, restarts and a full interval history.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: ends a run that hangs with a failure.
  initial begin
    #20_000_000;
    $display("Run timed out with %0d estimates outstanding.", pending);
    $display("FAILURE");
    $finish;
  end

endmodule
